/* sv/integer_to_base_digits_unit_defines.svh */
// Assertion macros shared by the integer-to-digits unit.
`ifndef INTEGER_TO_BASE_DIGITS_UNIT_DEFINES_SVH
`define INTEGER_TO_BASE_DIGITS_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ITB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Condition in any cycle implies result in the next cycle.
`define ITB_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define ITB_ASSERT(lbl, prop, msg)
`define ITB_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* sv/itob_pkg.sv */
// Shared types, constants and the digit-to-ASCII function.
package itob_pkg;

   localparam int VALUE_W        = 64;
   localparam int BASE_W         = 5;
   localparam int CHAR_W         = 7;
   localparam int DIGIT_W        = 4;
   localparam int MAX_DIGITS     = 64;
   localparam int ADDR_W         = $clog2(MAX_DIGITS);
   localparam int BITS_PER_CYCLE = 8;
   localparam int DIV_STEPS      = VALUE_W / BITS_PER_CYCLE;
   localparam int STEP_W         = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BASE_W-1:0]  BASE_MIN     = 5'd2;
   localparam logic [BASE_W-1:0]  BASE_MAX     = 5'd16;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'h61;

   // One conversion request after radix clamping
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0]  radix;
      logic               upper;
   } itob_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_EMIT
   } itob_state_type;

   // Map a digit value 0..15 to its ASCII code
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic up);
      logic [CHAR_W-1:0] letter_base;
      letter_base = up ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + CHAR_W'(d);
      end
      return letter_base + CHAR_W'(d - DIGIT_TEN);
   endfunction

endpackage

/* sv/integer_to_base_digits_unit.sv */
// Top level: 64-bit integer to ASCII digits in radix 2..16.
//
//   channel   direction  words                          handshake
//   req_      in         value, base, uppercase         req_valid / req_ready
//   rsp_      out        one character per digit, last  rsp_valid / rsp_ready
//
// Flow: for each digit the divider works through the 64-bit word 8 quotient
//   bits per step, then stores the digit; the digit buffer is then read back
//   most significant digit first, with one read in flight at a time.
// Reset: synchronous; clears control only. The digit buffer is written before
//   every read of it and needs no clearing.
// Stalls: a holding register and a two-word queue take new requests while the
//   back part works; the digit buffer lets the divider run ahead of rsp_ready.
module integer_to_base_digits_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [itob_pkg::VALUE_W-1:0] req_value,
   input  logic [itob_pkg::BASE_W-1:0]  req_base,
   input  logic                        req_uppercase,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [itob_pkg::CHAR_W-1:0] rsp_character,
   output logic                        rsp_last
);
   import itob_pkg::*;

   logic          push_valid;
   logic          push_ready;
   itob_item_type push_item;
   logic          pop_valid;
   logic          pop_ready;
   itob_item_type pop_item;

   itob_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_base      (req_base),
      .req_uppercase (req_uppercase),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   itob_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   itob_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_item      (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

/* sv/itob_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module itob_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/itob_fifo.sv */
// Short request queue between the front and back parts.
`include "integer_to_base_digits_unit_defines.svh"
module itob_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  itob_pkg::itob_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output itob_pkg::itob_item_type pop_item
);
   import itob_pkg::*;

   itob_item_type     ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = ent_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ITB_ASSERT(a_count_bound, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue fill count overflow")

endmodule

/* sv/itob_front.sv */
// Front part: takes request words, clamps the radix into 2..16, feeds the queue.
module itob_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [itob_pkg::VALUE_W-1:0] req_value,
   input  logic [itob_pkg::BASE_W-1:0]  req_base,
   input  logic                        req_uppercase,
   output logic                        push_valid,
   input  logic                        push_ready,
   output itob_pkg::itob_item_type     push_item
);
   import itob_pkg::*;

   logic          hold_valid_ff;
   logic          hold_valid_in;
   itob_item_type hold_item_ff;
   itob_item_type hold_item_in;
   logic          req_fire;

   assign req_ready  = !hold_valid_ff || push_ready;
   assign req_fire   = req_valid && req_ready;
   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

   // Classify: saturate the radix
   always_comb begin
      hold_item_in.value = req_value;
      hold_item_in.upper = req_uppercase;
      if (req_base < BASE_MIN) begin
         hold_item_in.radix = BASE_MIN;
      end else if (req_base > BASE_MAX) begin
         hold_item_in.radix = BASE_MAX;
      end else begin
         hold_item_in.radix = req_base;
      end
   end

   // Holding register valid
   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_fire) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_item_ff <= hold_item_in;
      end
   end

endmodule

/* sv/itob_back.sv */
// Back part: radix divider, digit buffer and most-significant-first emitter.
`include "integer_to_base_digits_unit_defines.svh"
module itob_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  itob_pkg::itob_item_type     pop_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [itob_pkg::CHAR_W-1:0] rsp_character,
   output logic                        rsp_last
);
   import itob_pkg::*;

   itob_state_type     state_ff;
   itob_state_type     state_in;
   logic [VALUE_W-1:0] quot_ff;
   logic [DIGIT_W-1:0] rem_ff;
   logic [BASE_W-1:0]  radix_ff;
   logic               upper_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [ADDR_W-1:0]  wr_idx_ff;
   logic [ADDR_W-1:0]  rd_idx_ff;
   logic               pend_ff;
   logic               pend_last_ff;
   logic               rsp_valid_ff;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic               rsp_last_ff;

   logic [VALUE_W-1:0] div_quot;
   logic [DIGIT_W-1:0] div_rem;
   logic               step_last;
   logic               digits_done;
   logic               rd_issue;
   logic               ram_wr_en;
   logic [DIGIT_W-1:0] ram_rd_data;

   assign step_last   = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign digits_done = (quot_ff == '0) || (wr_idx_ff == ADDR_W'(MAX_DIGITS - 1));

   // Restoring division, several quotient bits per cycle, MSB first
   always_comb begin : div_step
      logic [DIGIT_W:0]         part;
      logic [BITS_PER_CYCLE-1:0] qbits;
      part  = {1'b0, rem_ff};
      qbits = '0;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         part = {part[DIGIT_W-1:0], quot_ff[VALUE_W-1-i]};
         if (part >= radix_ff) begin
            part = part - radix_ff;
            qbits[BITS_PER_CYCLE-1-i] = 1'b1;
         end
      end
      div_rem  = part[DIGIT_W-1:0];
      div_quot = {quot_ff[VALUE_W-BITS_PER_CYCLE-1:0], qbits};
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = digits_done ? ST_EMIT : ST_DIV;
         end
         ST_EMIT: begin
            if (rd_issue && (rd_idx_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      pop_ready = 1'b0;
      ram_wr_en = 1'b0;
      rd_issue  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
         end
         ST_CHECK: begin
            ram_wr_en = 1'b1;
         end
         ST_EMIT: begin
            rd_issue = !pend_ff && (!rsp_valid_ff || rsp_ready);
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= rd_issue;
         if (state_ff == ST_DIV) begin
            step_ff <= step_ff + 1'b1;
         end else begin
            step_ff <= '0;
         end
      end
   end

   // Divider datapath and buffer indexes
   always_ff @(posedge clock) begin
      pend_last_ff <= (rd_idx_ff == '0);
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               quot_ff   <= pop_item.value;
               radix_ff  <= pop_item.radix;
               upper_ff  <= pop_item.upper;
               rem_ff    <= '0;
               wr_idx_ff <= '0;
            end
         end
         ST_DIV: begin
            quot_ff <= div_quot;
            rem_ff  <= div_rem;
         end
         ST_CHECK: begin
            rem_ff    <= '0;
            rd_idx_ff <= wr_idx_ff;
            if (!digits_done) begin
               wr_idx_ff <= wr_idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (rd_issue && (rd_idx_ff != '0)) begin
               rd_idx_ff <= rd_idx_ff - 1'b1;
            end
         end
         default: begin
            rem_ff <= rem_ff;
         end
      endcase
   end

   // Digit buffer, least significant digit at address zero
   itob_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_digits (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (rem_ff),
      .rd_en   (rd_issue),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rsp_char_ff <= digit_char(ram_rd_data, upper_ff);
         rsp_last_ff <= pend_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   `ITB_ASSERT(a_rem_below_radix, (state_ff == ST_CHECK) |-> (BASE_W'(rem_ff) < radix_ff), "digit not below radix")
   `ITB_ASSERT_NEXT(a_read_lands, pend_ff, rsp_valid_ff, "read data not captured in output register")
   `ITB_ASSERT(a_read_in_range, (state_ff == ST_EMIT) |-> (rd_idx_ff <= wr_idx_ff), "read beyond written digits")

endmodule

/* sim/tb_integer_to_base_digits_unit.sv */
// Testbench for the integer-to-digits unit: directed and random values, every digit checked.
module tb_integer_to_base_digits_unit;
   import itob_pkg::*;

   // One expected digit on the result channel
   typedef struct {
      logic [CHAR_W-1:0] character;
      logic              last;
   } digit_word_type;

   // Works out the digits of each accepted value and checks result words in order
   class digit_scoreboard;
      digit_word_type awaited[$];
      int             failures;
      string          upper_set;
      string          lower_set;

      function new();
         failures  = 0;
         upper_set = "0123456789ABCDEF";
         lower_set = "0123456789abcdef";
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Radix saturates to 2..16; digits come out least significant first,
      // so each new one goes to the front and the first one found is last.
      function void note_request(logic [VALUE_W-1:0] value, logic [BASE_W-1:0] base,
                                 logic upper);
         logic [VALUE_W-1:0] rest;
         logic [VALUE_W-1:0] radix;
         logic [DIGIT_W-1:0] digit;
         digit_word_type     word;
         digit_word_type     msd_first[$];
         radix = base;
         if (base < 5'd2) radix = 2;
         if (base > 5'd16) radix = 16;
         rest = value;
         do begin
            digit = DIGIT_W'(rest % radix);
            rest  = rest / radix;
            word.character = CHAR_W'(upper ? upper_set[digit] : lower_set[digit]);
            word.last      = (msd_first.size() == 0);
            msd_first.push_front(word);
         end while (rest != 0);
         foreach (msd_first[i]) awaited.push_back(msd_first[i]);
      endfunction

      function void check_digit(logic [CHAR_W-1:0] character, logic last);
         digit_word_type exp_word;
         if (awaited.size() == 0) begin
            $error("unexpected word: character %0d, last %0d", character, last);
            failures++;
            return;
         end
         exp_word = awaited.pop_front();
         if (character !== exp_word.character) begin
            $error("character: expected %0d, actual %0d", exp_word.character, character);
            failures++;
         end
         if (last !== exp_word.last) begin
            $error("last: expected %0d, actual %0d", exp_word.last, last);
            failures++;
         end
      endfunction
   endclass

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [VALUE_W-1:0]  req_value     = '0;
   logic [BASE_W-1:0]   req_base      = '0;
   logic                req_uppercase = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [CHAR_W-1:0]   rsp_character;
   logic                rsp_last;

   bit                  quiet_tail    = 1'b0;
   digit_scoreboard     board;

   integer_to_base_digits_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_base      (req_base),
      .req_uppercase (req_uppercase),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #1 clock = ~clock;

   // Present one word and hold it until accepted; valid stays high for the next call
   task automatic send_request(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base,
                               input logic upper);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= value;
      req_base      <= base;
      req_uppercase <= upper;
      do @(posedge clock); while (!req_ready);
      board.note_request(value, base, upper);
   endtask

   // Stop sending until every expected digit has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Result side: ready in random stretches, broken by stall bursts until quiet_tail is set
   initial begin
      int run_len;
      @(posedge clock);
      forever begin
         run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 30);
         rsp_ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         if (!quiet_tail) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   // Check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_digit(rsp_character, rsp_last);
   end

   // Stimulus and end of run
   initial begin
      logic [VALUE_W-1:0] rand_value;
      logic [BASE_W-1:0]  rand_base;
      int                 span;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero, one, extremes, sign-bit patterns, saturating radix
      send_request(64'd0, 5'd10, 1'b0);
      send_request(64'd1, 5'd2, 1'b0);
      send_request({VALUE_W{1'b1}}, 5'd2, 1'b0);
      send_request({VALUE_W{1'b1}}, 5'd16, 1'b1);
      send_request({VALUE_W{1'b1}}, 5'd16, 1'b0);
      send_request(64'h0123_4567_89AB_CDEF, 5'd16, 1'b1);
      send_request(64'hFEDC_BA98_7654_3210, 5'd16, 1'b0);
      send_request({VALUE_W{1'b1}}, 5'd10, 1'b0);
      send_request(64'h8000_0000_0000_0000, 5'd2, 1'b1);
      send_request(-64'sd12345, 5'd10, 1'b0);
      send_request(64'd255, 5'd0, 1'b0);
      send_request(64'd255, 5'd17, 1'b1);
      send_request(64'd255, 5'd31, 1'b0);
      for (int b = 3; b <= 15; b++) begin
         send_request(64'hDEAD_BEEF_CAFE_F00D + b, BASE_W'(b), b[0]);
      end
      settle();

      // random values of random length, mostly in-range radix
      for (int n = 0; n < 155; n++) begin
         if (n == 80) settle();
         if (n == 125) quiet_tail = 1'b1;
         span       = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 32)
                                                  : $urandom_range(33, VALUE_W);
         rand_value = {$urandom, $urandom};
         rand_value &= {VALUE_W{1'b1}} >> (VALUE_W - span);
         if ($urandom_range(0, 9) == 0) rand_value = '0;
         rand_base  = ($urandom_range(0, 9) < 8) ? BASE_W'($urandom_range(2, 16))
                                                 : BASE_W'($urandom_range(0, 31));
         send_request(rand_value, rand_base, 1'($urandom_range(0, 1)));
      end
      settle();
      repeat (800) @(posedge clock);

      if (board.failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Hard limit on run length
   initial begin
      #3000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
